/* src/itoar_pkg.sv */
package itoar_pkg;

    localparam int VALUE_BITS = 32;
    localparam int TDATA_W    = ((VALUE_BITS + 7) / 8) * 8;
    localparam int RADIX_W    = 6;
    localparam int DIGIT_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int DEPTH      = VALUE_BITS;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int STEP_W     = $clog2(VALUE_BITS);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

    localparam logic [CHAR_W-1:0]  CHR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0]  CHR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0]  CHR_MINUS   = 8'h2d;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS  = DIGIT_W'(10);

    typedef struct packed {
        logic               done;
        logic               quo_nz;
        logic [DIGIT_W-1:0] rem;
    } t_div_stat;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_DIGITS) begin
            c = CHR_ZERO + CHAR_W'(d);
        end else begin
            c = CHR_LOWER_A + CHAR_W'(d - DEC_DIGITS);
        end
        return c;
    endfunction

endpackage

/* src/itoar_div.sv */
module itoar_div
    import itoar_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [RADIX_W-1:0]    i_base,
    output logic [VALUE_BITS-1:0] o_quo,
    output t_div_stat             o_stat
);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [VALUE_BITS-1:0] r_quo;
    logic [DIGIT_W-1:0]    r_rem;
    logic                  r_nz;

    logic [DIGIT_W:0]      w_trial;
    logic                  w_qbit;
    logic [DIGIT_W-1:0]    n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[VALUE_BITS-1]};
        w_qbit  = (w_trial >= {1'b0, i_base});
        if (w_qbit) begin
            n_rem = DIGIT_W'(w_trial - {1'b0, i_base});
        end else begin
            n_rem = w_trial[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
            r_nz   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_nz   <= 1'b0;
            end else if (r_busy) begin
                r_nz <= r_nz | w_qbit;
                if (r_step == STEP_W'(VALUE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[VALUE_BITS-2:0], w_qbit};
            r_rem <= n_rem;
        end
    end

    assign o_quo         = r_quo;
    assign o_stat.done   = r_done;
    assign o_stat.quo_nz = r_nz;
    assign o_stat.rem    = r_rem;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("divider done without a finished run");
`endif

endmodule

/* src/itoar_stack.sv */
module itoar_stack
    import itoar_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_stk_ctl           i_ctl,
    input  logic [DIGIT_W-1:0] i_digit,
    output logic [DIGIT_W-1:0] o_top,
    output logic [CNT_W-1:0]   o_cnt
);

    logic [DIGIT_W-1:0] r_stk [DEPTH];
    logic [CNT_W-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.push) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (i_ctl.pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Shift in on push, shift out on pop; the top stays at entry zero.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_stk[0] <= i_digit;
            for (int i = 1; i < DEPTH; i++) begin
                r_stk[i] <= r_stk[i-1];
            end
        end else if (i_ctl.pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_stk[i] <= r_stk[i+1];
            end
            r_stk[DEPTH-1] <= '0;
        end
    end

    assign o_top = r_stk[0];
    assign o_cnt = r_cnt;

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> r_cnt != '0 && !i_ctl.push)
        else $error("digit stack popped while empty");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> r_cnt != CNT_W'(DEPTH))
        else $error("digit stack overflow");
`endif

endmodule

/* src/signed_integer_to_ascii_radix.sv */
// Flow: the magnitude is divided by the radix again and again, one digit per division;
//   the characters then go out one per cycle while m_axis_tready is high.
// Input: a new value is taken only when idle, after the last character is loaded;
//   the bit-serial divider works out one quotient bit a cycle.
// Reset: synchronous, active low; clears control, empties the digit stack, radix to 10.
module signed_integer_to_ascii_radix
    import itoar_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_radix_we,
    input  logic [RADIX_W-1:0] i_radix_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // value
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [CHAR_W-1:0]  m_axis_tdata,   // char_out
    output logic               m_axis_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]            r_state;
    logic [RADIX_W-1:0]    r_radix;
    logic                  r_neg;
    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_char;
    logic                  r_last;

    logic                  w_accept;
    logic signed [VALUE_BITS-1:0] w_value;
    logic [VALUE_BITS-1:0] w_mag;
    logic [RADIX_W-1:0]    w_base;
    logic                  w_start;
    logic [VALUE_BITS-1:0] w_dividend;
    logic [VALUE_BITS-1:0] w_quo;
    t_div_stat             w_stat;
    t_stk_ctl              w_ctl;
    logic [DIGIT_W-1:0]    w_top;
    logic [CNT_W-1:0]      w_cnt;
    logic                  w_load;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_value       = s_axis_tdata[VALUE_BITS-1:0];
    assign w_mag         = w_value[VALUE_BITS-1] ? (~w_value + VALUE_BITS'(1)) : w_value;

    always_comb begin
        if (r_radix < RADIX_MIN) begin
            w_base = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            w_base = RADIX_MAX;
        end else begin
            w_base = r_radix;
        end
    end

    assign w_start    = w_accept || ((r_state == ST_DIV) && w_stat.done && w_stat.quo_nz);
    assign w_dividend = w_accept ? w_mag : w_quo;
    assign w_load     = (r_state == ST_EMIT) && (!r_out_valid || m_axis_tready);

    assign w_ctl.push = (r_state == ST_DIV) && w_stat.done;
    assign w_ctl.pop  = w_load && !r_neg;

    itoar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_base     (w_base),
        .o_quo      (w_quo),
        .o_stat     (w_stat)
    );

    itoar_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_digit (w_stat.rem),
        .o_top   (w_top),
        .o_cnt   (w_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_radix_we) begin
            r_radix <= i_radix_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_neg   <= w_value[VALUE_BITS-1];
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_stat.done && !w_stat.quo_nz) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_load) begin
                        if (r_neg) begin
                            r_neg <= 1'b0;
                        end else if (w_cnt == CNT_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_neg) begin
                r_char <= CHR_MINUS;
                r_last <= 1'b0;
            end else begin
                r_char <= digit_char(w_top);
                r_last <= (w_cnt == CNT_W'(1));
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_char;
    assign m_axis_tlast  = r_last;

`ifndef SYNTHESIS
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> w_cnt == '0)
        else $error("digit stack not empty when idle");
`endif

endmodule
